// File: hw/rtl/qdp_pkg.sv
// ----------------------------------------------------------------------------
// qdp_pkg
// Shared widths, register codes and inter-stage types of the int8/int4
// dot-product unit.
// ----------------------------------------------------------------------------
package qdp_pkg;

  localparam int ACT_W  = 8;
  localparam int WB_W   = 8;
  localparam int NIB_W  = 4;
  localparam int ADD_W  = 16;
  localparam int ACC_W  = 32;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [NIB_W-1:0] INT4_OFFSET_RST = 4'd8;

  typedef enum logic {
    REG_WEIGHT_FORMAT = 1'b0,
    REG_INT4_OFFSET   = 1'b1
  } qdp_reg_e;

  typedef enum logic {
    FMT_INT8 = 1'b0,
    FMT_INT4 = 1'b1
  } qdp_fmt_e;

  typedef struct packed {
    qdp_fmt_e               weight_format;
    logic [NIB_W-1:0]       int4_offset;
  } qdp_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [ADD_W-1:0] add;
  } qdp_term_t;

endpackage

// File: hw/rtl/qdp_if.sv
// ----------------------------------------------------------------------------
// qdp_if
// Request and result channels of the dot-product unit.
// ----------------------------------------------------------------------------
interface qdp_req_if
  import qdp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ACT_W-1:0] act_first;
  logic signed [ACT_W-1:0] act_second;
  logic [WB_W-1:0]         weight_byte;
  logic                    high_present;
  logic                    last_item;

  modport source (
    output valid, act_first, act_second, weight_byte, high_present, last_item,
    input  ready
  );
  modport sink (
    input  valid, act_first, act_second, weight_byte, high_present, last_item,
    output ready
  );
endinterface

interface qdp_res_if
  import qdp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] dot_sum;

  modport source (
    output valid, dot_sum,
    input  ready
  );
  modport sink (
    input  valid, dot_sum,
    output ready
  );
endinterface

// File: hw/rtl/quantized_int8_int4_dot_product_unit.sv
// ----------------------------------------------------------------------------
// quantized_int8_int4_dot_product_unit
// Row dot product of signed int8 activations with int8 or packed int4
// weights, one weight byte per request.
//
// Channel   Dir   Handshake          Payload
// req_i     in    valid/ready        act_first, act_second, weight_byte,
//                                    high_present, last_item
// res_o     out   valid/ready        dot_sum
// APB       in    psel/penable       weight_format @0x0, int4_offset @0x4
//
// One request per cycle unless a waiting result stalls the pipeline; input
// register, product register, then accumulator and result register, which
// takes dot_sum from the last_item term. A waiting result stalls only a
// following last_item term; other terms keep accumulating. Reset clears the
// accumulator, the valid bits and the registers (format int8, offset 8).
// ----------------------------------------------------------------------------
module quantized_int8_int4_dot_product_unit
  import qdp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  qdp_req_if.sink           req_i,
  qdp_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  qdp_cfg_t  cfg;
  qdp_term_t term;
  logic      term_ready;

  qdp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qdp_prod u_prod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg),
    .term_o       (term),
    .term_ready_i (term_ready)
  );

  qdp_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_i       (term),
    .term_ready_o (term_ready),
    .res_o        (res_o)
  );

endmodule

// File: hw/rtl/qdp_apb_regs.sv
// ----------------------------------------------------------------------------
// qdp_apb_regs
// APB register file holding the weight format and the int4 offset.
// ----------------------------------------------------------------------------
module qdp_apb_regs
  import qdp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output qdp_cfg_t          cfg_o
);

  qdp_cfg_t cfg_q, cfg_d;
  qdp_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = qdp_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_WEIGHT_FORMAT: cfg_d.weight_format = qdp_fmt_e'(pwdata[0]);
        REG_INT4_OFFSET:   cfg_d.int4_offset   = pwdata[NIB_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WEIGHT_FORMAT: prdata = {{(APB_DW-1){1'b0}}, cfg_q.weight_format};
      REG_INT4_OFFSET:   prdata = {{(APB_DW-NIB_W){1'b0}}, cfg_q.int4_offset};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_format <= FMT_INT8;
      cfg_q.int4_offset   <= INT4_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/qdp_prod.sv
// ----------------------------------------------------------------------------
// qdp_prod
// Input register and product stage: forms the per-request term from the
// int8 weight, or the low int4 nibble plus the high one if high_present.
// ----------------------------------------------------------------------------
module qdp_prod
  import qdp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  qdp_req_if.sink   req_i,
  input  qdp_cfg_t  cfg_i,
  output qdp_term_t term_o,
  input  logic      term_ready_i
);

  logic                    s0_valid_q, s0_valid_d;
  logic signed [ACT_W-1:0] a0_q, a1_q;
  logic [WB_W-1:0]         wb_q;
  logic                    hp_q, last_q;

  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_last_q;
  logic [ADD_W-1:0]        s1_add_q, add_d;

  logic                    accept, s1_free, s0_move, use_hi;
  logic signed [ACT_W:0]   w_lo;
  logic signed [NIB_W:0]   w_hi;
  logic signed [16:0]      p_lo, sum_full;
  logic signed [12:0]      p_hi, p_hi_sel;

  assign s1_free     = !s1_valid_q || term_ready_i;
  assign s0_move     = s0_valid_q && s1_free;
  assign req_i.ready = !s0_valid_q || s1_free;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    if (cfg_i.weight_format == FMT_INT4) begin
      w_lo = $signed({5'b0, wb_q[NIB_W-1:0]}) - $signed({5'b0, cfg_i.int4_offset});
    end else begin
      w_lo = $signed({wb_q[WB_W-1], wb_q});
    end
    w_hi     = $signed({1'b0, wb_q[WB_W-1:NIB_W]}) - $signed({1'b0, cfg_i.int4_offset});
    use_hi   = (cfg_i.weight_format == FMT_INT4) && hp_q;
    p_lo     = a0_q * w_lo;
    p_hi     = a1_q * w_hi;
    p_hi_sel = use_hi ? p_hi : 13'sd0;
    sum_full = p_lo + p_hi_sel;
    add_d    = sum_full[ADD_W-1:0];
  end

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (accept) begin
      s0_valid_d = 1'b1;
    end else if (s0_move) begin
      s0_valid_d = 1'b0;
    end
    s1_valid_d = s1_free ? s0_valid_q : s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a0_q   <= req_i.act_first;
      a1_q   <= req_i.act_second;
      wb_q   <= req_i.weight_byte;
      hp_q   <= req_i.high_present;
      last_q <= req_i.last_item;
    end
    if (s0_move) begin
      s1_add_q  <= add_d;
      s1_last_q <= last_q;
    end
  end

  assign term_o.valid = s1_valid_q;
  assign term_o.last  = s1_last_q;
  assign term_o.add   = s1_add_q;

endmodule

// File: hw/rtl/qdp_accum.sv
// ----------------------------------------------------------------------------
// qdp_accum
// Row accumulator and result register; emits the sum on the last term of a
// row and clears the accumulator.
// ----------------------------------------------------------------------------
module qdp_accum
  import qdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qdp_term_t  term_i,
  output logic       term_ready_o,
  qdp_res_if.source  res_o
);

  logic [ACC_W-1:0] acc_q, acc_d, sum;
  logic [ACC_W-1:0] dot_sum_q;
  logic             res_valid_q, res_valid_d;
  logic             out_free, retire, emit;

  assign out_free     = !res_valid_q || res_o.ready;
  assign term_ready_o = !term_i.last || out_free;
  assign retire       = term_i.valid && term_ready_o;
  assign emit         = retire && term_i.last;
  assign sum          = acc_q + {{(ACC_W-ADD_W){term_i.add[ADD_W-1]}}, term_i.add};

  always_comb begin
    acc_d = acc_q;
    if (retire) begin
      acc_d = term_i.last ? '0 : sum;
    end
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dot_sum_q <= sum;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.dot_sum = dot_sum_q;

  a_acc_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && !term_i.last) |=> (acc_q == $past(sum)))
    else $error("accumulator did not add the retired term");

  a_row_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (res_valid_q && acc_q == '0 && dot_sum_q == $past(sum)))
    else $error("row end did not publish the sum and clear the accumulator");

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !retire |=> $stable(acc_q))
    else $error("accumulator changed without a retired term");

endmodule
